@@ rtl/sgdb_pkg.sv @@
// Shared types, constants and helpers of the scatter-gather descriptor builder.
// No dependencies; the interfaces, the register block and the top level use this package.
package sgdb_pkg;

	// Sizing of the descriptor chain
	localparam int MAX_PAGES   = 32;
	localparam int PAGE_BYTES  = 4096;
	localparam int DESC_BYTES  = 16;
	localparam int TABLE_DEPTH = MAX_PAGES + 2;

	localparam int PAGE_W     = $clog2(PAGE_BYTES);
	localparam int DESC_SHIFT = $clog2(DESC_BYTES);
	localparam int IDX_W      = $clog2(TABLE_DEPTH);

	// Field widths
	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 24;
	localparam int CNT_W   = 13;
	localparam int LIMIT_W = 6;
	localparam int MLEN_W  = 18;
	localparam int RES_W   = 6;

	// Configuration port
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 4;

	localparam logic [1:0] ALIGN_MASK = 2'h3;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DESC_BASE,
		REG_PAGE_LIMIT,
		REG_EXTRA_TERM
	} reg_idx_t;

	// Request kinds
	typedef enum logic {
		KIND_MAP,
		KIND_ADVANCE
	} kind_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  desc_base;
		logic [LIMIT_W-1:0] page_limit;
		logic               extra_term;
	} cfg_t;

	// One stored descriptor
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  count;
		logic              term;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP,
		ST_TERM,
		ST_ZERO,
		ST_MISALIGN,
		ST_ADV_RD1,
		ST_ADV_SUB,
		ST_ADV_SKIP,
		ST_ADV_TCHK,
		ST_ADV_TRIM,
		ST_ADV_FIN,
		ST_ADV_LOAD,
		ST_ADV_EMIT
	} state_t;

	// Address of the descriptor that follows table entry idx
	function automatic logic [ADDR_W-1:0] desc_next(input logic [ADDR_W-1:0] base,
			input logic [IDX_W-1:0] idx);
		logic [ADDR_W-1:0] succ;
		succ = ADDR_W'(idx) + ADDR_W'(1);
		return base + (succ << DESC_SHIFT);
	endfunction

endpackage

@@ rtl/sgdb_req_if.sv @@
// Request channel of the descriptor builder: valid/ready plus one request item.
// Depends on sgdb_pkg for field widths.
interface sgdb_req_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [sgdb_pkg::ADDR_W-1:0]  buffer_address;
	logic [sgdb_pkg::LEN_W-1:0]   request_length;
	logic [sgdb_pkg::LEN_W-1:0]   bytes_moved;

	modport source (output valid, kind, buffer_address, request_length, bytes_moved,
		input ready);
	modport sink (input valid, kind, buffer_address, request_length, bytes_moved,
		output ready);
endinterface

@@ rtl/sgdb_desc_if.sv @@
// Result channel of the descriptor builder: valid/ready plus one descriptor item.
// Depends on sgdb_pkg for field widths.
interface sgdb_desc_if;
	logic                         valid;
	logic                         ready;
	logic [sgdb_pkg::ADDR_W-1:0]  desc_address;
	logic [sgdb_pkg::CNT_W-1:0]   desc_count;
	logic [sgdb_pkg::ADDR_W-1:0]  desc_next;
	logic                         desc_end;
	logic [sgdb_pkg::RES_W-1:0]   resume_index;
	logic [sgdb_pkg::MLEN_W-1:0]  mapped_length;
	logic                         last;

	modport source (output valid, desc_address, desc_count, desc_next, desc_end,
		resume_index, mapped_length, last, input ready);
	modport sink (input valid, desc_address, desc_count, desc_next, desc_end,
		resume_index, mapped_length, last, output ready);
endinterface

@@ rtl/sgdb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sgdb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/sgdb_apb_regs.sv @@
// APB configuration registers of the descriptor builder: base, page limit, terminator mode.
// Depends on sgdb_pkg for the register indexes and the cfg_t struct.
module sgdb_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sgdb_pkg::PADDR_W-1:0]  paddr,
	input  logic [sgdb_pkg::PDATA_W-1:0]  pwdata,
	output logic [sgdb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output sgdb_pkg::cfg_t                cfg
);
	import sgdb_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.desc_base  <= '0;
			cfg_q.page_limit <= LIMIT_W'(MAX_PAGES);
			cfg_q.extra_term <= 1'b1;
		end else if (wr_en) begin
			unique case (idx)
				REG_DESC_BASE:  cfg_q.desc_base  <= pwdata[ADDR_W-1:0];
				REG_PAGE_LIMIT: cfg_q.page_limit <= pwdata[LIMIT_W-1:0];
				REG_EXTRA_TERM: cfg_q.extra_term <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (idx)
			REG_DESC_BASE:  prdata = PDATA_W'(cfg_q.desc_base);
			REG_PAGE_LIMIT: prdata = PDATA_W'(cfg_q.page_limit);
			REG_EXTRA_TERM: prdata = PDATA_W'(cfg_q.extra_term);
			default:        prdata = '0;
		endcase
	end
endmodule

@@ rtl/sg_dma_descriptor_builder_unit.sv @@
// Scatter-gather descriptor builder top level: sequencer, descriptor table, output register.
// Depends on sgdb_pkg, sgdb_req_if, sgdb_desc_if, sgdb_ram and sgdb_apb_regs.
//
// A map request splits a buffer at page boundaries into descriptors, stores each one in
// a 34-entry table RAM and sends it out, one descriptor per cycle while the sink keeps
// ready high; with the terminator mode on, a zero-count end descriptor follows. A map
// item gives up to page limit + 1 results, and the next item is accepted as soon as the
// last result sits in the output register. A misaligned or zero-length map gives a
// single result. An advance request walks the table through the single RAM read port,
// one read per step; it trims the partly sent descriptor in place and returns the entry
// at the new resume index. The table needs no clearing after reset: only entries
// written by the latest map are ever used.
module sg_dma_descriptor_builder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	sgdb_req_if.sink                      req,
	sgdb_desc_if.source                   desc,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sgdb_pkg::PADDR_W-1:0]  paddr,
	input  logic [sgdb_pkg::PDATA_W-1:0]  pwdata,
	output logic [sgdb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import sgdb_pkg::*;

	cfg_t   cfg;
	state_t state_q, state_nxt;

	// Control state
	logic                 out_valid_q;
	logic [IDX_W-1:0]     resume_q;
	logic [IDX_W-1:0]     chain_q;

	// Work registers
	logic [ADDR_W-1:0]    p_q;
	logic [LEN_W-1:0]     rem_q;
	logic [MLEN_W-1:0]    sum_q;
	logic [IDX_W-1:0]     k_q;
	logic [LIMIT_W-1:0]   lim_q;
	logic [LEN_W-1:0]     x_q;
	logic [IDX_W-1:0]     r_q;
	entry_t               e_q;

	// Output register
	logic [ADDR_W-1:0]    o_addr_q;
	logic [CNT_W-1:0]     o_cnt_q;
	logic [ADDR_W-1:0]    o_next_q;
	logic                 o_end_q;
	logic [RES_W-1:0]     o_res_q;
	logic [MLEN_W-1:0]    o_mlen_q;
	logic                 o_last_q;

	// RAM port
	logic                 ram_we, ram_re;
	logic [IDX_W-1:0]     ram_waddr;
	entry_t               ram_wdata, ram_rdata;

	// Step values
	logic                 accept, out_free;
	logic [LIMIT_W-1:0]   lim;
	logic [IDX_W-1:0]     r_start;
	logic [CNT_W-1:0]     room, chunk;
	logic                 fin;
	logic [CNT_W:0]       r_sum;
	logic [IDX_W-1:0]     r_sat;
	logic [CNT_W-1:0]     off, trim;
	entry_t               trimmed;

	// Output load
	logic                 o_load;
	logic [ADDR_W-1:0]    o_addr, o_next;
	logic [CNT_W-1:0]     o_cnt;
	logic                 o_end, o_last;
	logic [RES_W-1:0]     o_res;
	logic [MLEN_W-1:0]    o_mlen;

	sgdb_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sgdb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (r_q),
		.rdata (ram_rdata)
	);

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || desc.ready;

	// Clamp the page limit into 1..MAX_PAGES
	always_comb begin
		if (cfg.page_limit == '0) begin
			lim = LIMIT_W'(1);
		end else if (cfg.page_limit > LIMIT_W'(MAX_PAGES)) begin
			lim = LIMIT_W'(MAX_PAGES);
		end else begin
			lim = cfg.page_limit;
		end
	end

	assign r_start = (resume_q > chain_q) ? chain_q : resume_q;

	// Next descriptor of a map: stop at the page end or at the end of the buffer; the chain also ends at the page limit
	assign room  = CNT_W'(PAGE_BYTES) - CNT_W'(p_q[PAGE_W-1:0]);
	assign chunk = (rem_q < LEN_W'(room)) ? rem_q[CNT_W-1:0] : room;
	assign fin   = (rem_q == LEN_W'(chunk)) || (LIMIT_W'(k_q) + LIMIT_W'(1) == lim_q);

	// Skip whole pages of an advance, saturated at the chain length
	assign r_sum = (CNT_W+1)'(r_q) + (CNT_W+1)'(x_q[LEN_W-1:PAGE_W]);
	assign r_sat = (r_sum > (CNT_W+1)'(chain_q)) ? chain_q : r_sum[IDX_W-1:0];

	// Trim the partly sent descriptor
	assign off             = CNT_W'(x_q[PAGE_W-1:0]);
	assign trim            = (off > ram_rdata.count) ? ram_rdata.count : off;
	assign trimmed.addr    = ram_rdata.addr + ADDR_W'(trim);
	assign trimmed.count   = ram_rdata.count - trim;
	assign trimmed.term    = ram_rdata.term;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.kind == KIND_ADVANCE) begin
						if (req.bytes_moved == '0 || r_start >= chain_q) begin
							state_nxt = ST_ADV_FIN;
						end else begin
							state_nxt = ST_ADV_RD1;
						end
					end else if ((req.buffer_address[1:0] & ALIGN_MASK) != '0) begin
						state_nxt = ST_MISALIGN;
					end else if (req.request_length == '0) begin
						state_nxt = ST_ZERO;
					end else begin
						state_nxt = ST_MAP;
					end
				end
			end
			ST_MAP: begin
				if (out_free && fin) begin
					state_nxt = cfg.extra_term ? ST_TERM : ST_IDLE;
				end
			end
			ST_TERM, ST_ZERO, ST_MISALIGN, ST_ADV_EMIT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_ADV_RD1:  state_nxt = ST_ADV_SUB;
			ST_ADV_SUB:  state_nxt = ST_ADV_SKIP;
			ST_ADV_SKIP: state_nxt = (x_q == '0) ? ST_ADV_FIN : ST_ADV_TCHK;
			ST_ADV_TCHK: state_nxt = (r_q < chain_q) ? ST_ADV_TRIM : ST_ADV_FIN;
			ST_ADV_TRIM: state_nxt = ST_ADV_EMIT;
			ST_ADV_FIN:  state_nxt = (r_q < chain_q) ? ST_ADV_LOAD : ST_ADV_EMIT;
			ST_ADV_LOAD: state_nxt = ST_ADV_EMIT;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake, RAM access, output register load
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = '0;
		o_load    = 1'b0;
		o_addr    = '0;
		o_cnt     = '0;
		o_next    = desc_next(cfg.desc_base, k_q);
		o_end     = 1'b1;
		o_res     = '0;
		o_mlen    = '0;
		o_last    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_MAP: begin
				if (out_free) begin
					ram_we          = 1'b1;
					ram_wdata.addr  = p_q;
					ram_wdata.count = chunk;
					ram_wdata.term  = fin && !cfg.extra_term;
					o_load          = 1'b1;
					o_addr          = p_q;
					o_cnt           = chunk;
					o_end           = fin && !cfg.extra_term;
					o_last          = fin && !cfg.extra_term;
					o_mlen          = o_last ? (sum_q + MLEN_W'(chunk)) : '0;
				end
			end
			ST_TERM: begin
				if (out_free) begin
					ram_we         = 1'b1;
					ram_wdata.term = 1'b1;
					o_load         = 1'b1;
					o_mlen         = sum_q;
				end
			end
			ST_ZERO: begin
				if (out_free) begin
					ram_we         = 1'b1;
					ram_waddr      = '0;
					ram_wdata.term = 1'b1;
					o_load         = 1'b1;
					o_next         = desc_next(cfg.desc_base, '0);
				end
			end
			ST_MISALIGN: begin
				if (out_free) begin
					o_load = 1'b1;
					o_next = '0;
					o_end  = 1'b0;
					o_res  = RES_W'(resume_q);
				end
			end
			ST_ADV_RD1, ST_ADV_TCHK, ST_ADV_FIN: begin
				ram_re = 1'b1;
			end
			ST_ADV_TRIM: begin
				ram_we    = 1'b1;
				ram_waddr = r_q;
				ram_wdata = trimmed;
			end
			ST_ADV_EMIT: begin
				if (out_free) begin
					o_load = 1'b1;
					o_addr = e_q.addr;
					o_cnt  = e_q.count;
					o_end  = e_q.term;
					o_next = desc_next(cfg.desc_base, r_q);
					o_res  = RES_W'(r_q);
				end
			end
			default: ;
		endcase
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			resume_q    <= '0;
			chain_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (o_load) begin
				out_valid_q <= 1'b1;
			end else if (desc.ready) begin
				out_valid_q <= 1'b0;
			end
			// Restart the resume point on any aligned map
			if (accept && req.kind == KIND_MAP &&
					(req.buffer_address[1:0] & ALIGN_MASK) == '0) begin
				resume_q <= '0;
			end
			if (state_q == ST_ADV_EMIT && out_free) begin
				resume_q <= r_q;
			end
			// Record the chain length when its last entry is written
			if (state_q == ST_ZERO && out_free) begin
				chain_q <= IDX_W'(1);
			end
			if (state_q == ST_MAP && out_free && fin && !cfg.extra_term) begin
				chain_q <= k_q + IDX_W'(1);
			end
			if (state_q == ST_TERM && out_free) begin
				chain_q <= k_q + IDX_W'(1);
			end
		end
	end

	// Work registers
	always_ff @(posedge clk) begin
		if (accept) begin
			p_q   <= req.buffer_address;
			rem_q <= req.request_length;
			sum_q <= '0;
			k_q   <= '0;
			lim_q <= lim;
			x_q   <= req.bytes_moved;
			r_q   <= r_start;
		end
		unique case (state_q)
			ST_MAP: begin
				if (out_free) begin
					p_q   <= p_q + ADDR_W'(chunk);
					rem_q <= rem_q - LEN_W'(chunk);
					sum_q <= sum_q + MLEN_W'(chunk);
					k_q   <= k_q + IDX_W'(1);
				end
			end
			ST_ADV_SUB: begin
				// Consume the descriptor at the resume point when fully moved
				if (x_q >= LEN_W'(ram_rdata.count)) begin
					x_q <= x_q - LEN_W'(ram_rdata.count);
					r_q <= r_q + IDX_W'(1);
				end
			end
			ST_ADV_SKIP: begin
				if (x_q != '0) begin
					r_q <= r_sat;
				end
			end
			ST_ADV_TRIM: begin
				e_q <= trimmed;
			end
			ST_ADV_FIN: begin
				if (r_q >= chain_q) begin
					e_q.addr  <= '0;
					e_q.count <= '0;
					e_q.term  <= 1'b1;
				end
			end
			ST_ADV_LOAD: begin
				e_q <= ram_rdata;
			end
			default: ;
		endcase
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (o_load) begin
			o_addr_q <= o_addr;
			o_cnt_q  <= o_cnt;
			o_next_q <= o_next;
			o_end_q  <= o_end;
			o_res_q  <= o_res;
			o_mlen_q <= o_mlen;
			o_last_q <= o_last;
		end
	end

	assign desc.valid         = out_valid_q;
	assign desc.desc_address  = o_addr_q;
	assign desc.desc_count    = o_cnt_q;
	assign desc.desc_next     = o_next_q;
	assign desc.desc_end      = o_end_q;
	assign desc.resume_index  = o_res_q;
	assign desc.mapped_length = o_mlen_q;
	assign desc.last          = o_last_q;
endmodule
